// ===== rtl/core/pcg_pkg.sv =====
// shared types and constants of the pixel channel generator
`timescale 1ns / 1ps

package pcg_pkg;

  // fill mode codes
  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_SET   = 3'd1,
    MODE_DIST  = 3'd2,
    MODE_RED   = 3'd3,
    MODE_GREEN = 3'd4,
    MODE_BLUE  = 3'd5
  } mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FILL_MODE     = 3'd0,
    REG_INVERT_OUTPUT = 3'd1,
    REG_REF_RED       = 3'd2,
    REG_REF_GREEN     = 3'd3,
    REG_REF_BLUE      = 3'd4,
    REG_RADIUS_SCALE  = 3'd5
  } cfg_reg_t;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned DIST_W = 18;   // sum of three squared byte differences
  localparam int unsigned PROD_W = 50;   // 32 bit scale times 18 bit distance
  localparam int unsigned KEY_W  = 16;   // integer part of the scaled distance
  localparam int unsigned ROOT_W = 5;    // root of a 10 bit value
  localparam int unsigned NUM_W  = 12;   // refinement numerator
  localparam int unsigned DIV_W  = 9;    // refinement divisor
  localparam int unsigned QUO_W  = 4;

  localparam logic [31:0] RADIUS_RESET = 32'd4261478400;  // 65025.0 in q16.16
  localparam logic [31:0] SAT_LIMIT    = 32'd4261478400;  // 65025 << 16
  localparam logic [KEY_W-1:0] SMALL_LIMIT = 16'd1024;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // floor square root of a 10 bit value, one result bit per step
  function automatic logic [ROOT_W-1:0] isqrt10(input logic [9:0] x);
    logic [ROOT_W-1:0] res;
    logic [ROOT_W-1:0] trial;
    logic [9:0] sq;
    res = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = res | (ROOT_W'(1) << i);
      sq = 10'(trial) * 10'(trial);
      if (sq <= x) begin
        res = trial;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pixel_channel_generator_core.sv =====
// top level of the pixel channel generator: seven stage pipeline
`timescale 1ns / 1ps
//
// usage
//   input channel:  in_valid / in_ready with one rgb pixel word (pix_red, pix_green,
//                   pix_blue); output channel: out_valid / out_ready with one byte
//                   chan_value per pixel, in input order
//   config channel: cfg_valid / cfg_ready (always ready), cfg_index selects the
//                   register, cfg_data carries the value; indexes above five are
//                   dropped. write only while no pixel is in flight
//   pipe: an accepted word moves through stages one to six into the output register
//   throughput: one pixel per clock; the whole pipe advances together, so a stall
//     on the output freezes every stage and in_ready follows out_ready whenever the
//     output register holds a word
//   distance path: squares and sum, 32x18 scale multiply, saturation check and
//     seed root, seed square and numerator, two stages of a 4 bit restoring divide,
//     then final square, downward fix and mode select into the output register
//   reset: rst (synchronous) empties the pipe and loads the register reset values
//     (clear mode, no invert, colour a black, scale 65025.0)
//
module pixel_channel_generator_core (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pix_red,
  input  logic [7:0]  pix_green,
  input  logic [7:0]  pix_blue,
  // channel output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  chan_value,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [2:0]  fill_mode;
  logic        invert_output;
  logic [7:0]  ref_red;
  logic [7:0]  ref_green;
  logic [7:0]  ref_blue;
  logic [31:0] radius_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode     <= pcg_pkg::MODE_CLEAR;
      invert_output <= 1'b0;
      ref_red       <= '0;
      ref_green     <= '0;
      ref_blue      <= '0;
      radius_scale  <= pcg_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcg_pkg::REG_FILL_MODE:     fill_mode     <= cfg_data[2:0];
        pcg_pkg::REG_INVERT_OUTPUT: invert_output <= cfg_data[0];
        pcg_pkg::REG_REF_RED:       ref_red       <= cfg_data[7:0];
        pcg_pkg::REG_REF_GREEN:     ref_green     <= cfg_data[7:0];
        pcg_pkg::REG_REF_BLUE:      ref_blue      <= cfg_data[7:0];
        pcg_pkg::REG_RADIUS_SCALE:  radius_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: every stage moves when the output register is free or taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // valid bits, one per stage; stage 7 is the output register
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  // stage 1: squared distance to colour a, plus the value of the non-distance modes
  logic [7:0]  dr, dg, db;
  logic [pcg_pkg::DIST_W-1:0] dist_sum;
  logic [7:0]  plain_val;
  logic [pcg_pkg::DIST_W-1:0] s1_dist;
  logic [7:0]  s1_plain;

  always_comb begin
    dr = (pix_red   > ref_red)   ? pix_red   - ref_red   : ref_red   - pix_red;
    dg = (pix_green > ref_green) ? pix_green - ref_green : ref_green - pix_green;
    db = (pix_blue  > ref_blue)  ? pix_blue  - ref_blue  : ref_blue  - pix_blue;
    dist_sum = pcg_pkg::DIST_W'(16'(dr) * 16'(dr)) + pcg_pkg::DIST_W'(16'(dg) * 16'(dg))
             + pcg_pkg::DIST_W'(16'(db) * 16'(db));
    case (fill_mode)
      pcg_pkg::MODE_SET:   plain_val = pcg_pkg::CHAN_MAX;
      pcg_pkg::MODE_RED:   plain_val = pix_red;
      pcg_pkg::MODE_GREEN: plain_val = pix_green;
      pcg_pkg::MODE_BLUE:  plain_val = pix_blue;
      default:             plain_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dist  <= dist_sum;
      s1_plain <= plain_val;
    end
  end

  // stage 2: q16.16 scaling
  logic [pcg_pkg::PROD_W-1:0] s2_prod;
  logic [7:0] s2_plain;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod  <= pcg_pkg::PROD_W'(radius_scale) * pcg_pkg::PROD_W'(s1_dist);
      s2_plain <= s1_plain;
    end
  end

  // stage 3: saturation check, integer part, seed root from a 10 bit slice
  logic sat_c, small_c;
  logic [pcg_pkg::KEY_W-1:0] key_c;
  logic [pcg_pkg::ROOT_W-1:0] root_c;
  logic s3_sat, s3_small;
  logic [pcg_pkg::KEY_W-1:0] s3_key;
  logic [pcg_pkg::ROOT_W-1:0] s3_root;
  logic [7:0] s3_plain;

  always_comb begin
    sat_c   = s2_prod >= pcg_pkg::PROD_W'(pcg_pkg::SAT_LIMIT);
    key_c   = s2_prod[31:16];
    small_c = key_c < pcg_pkg::SMALL_LIMIT;
    root_c  = pcg_pkg::isqrt10(small_c ? key_c[9:0] : key_c[15:6]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sat   <= sat_c;
      s3_small <= small_c;
      s3_key   <= key_c;
      s3_root  <= root_c;
      s3_plain <= s2_plain;
    end
  end

  // stage 4: seed is root*8; numerator k - seed^2, divisor 2*seed
  logic [15:0] seed_sq;
  logic [pcg_pkg::KEY_W-1:0] num_full;
  logic s4_sat, s4_small;
  logic [pcg_pkg::KEY_W-1:0] s4_key;
  logic [pcg_pkg::ROOT_W-1:0] s4_root;
  logic [pcg_pkg::NUM_W-1:0] s4_num;
  logic [pcg_pkg::DIV_W-1:0] s4_div;
  logic [7:0] s4_plain;

  always_comb begin
    seed_sq  = 16'({s3_root, 3'b000}) * 16'({s3_root, 3'b000});
    num_full = s3_key - seed_sq;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sat   <= s3_sat;
      s4_small <= s3_small;
      s4_key   <= s3_key;
      s4_root  <= s3_root;
      s4_num   <= num_full[pcg_pkg::NUM_W-1:0];   // bounded by 128*root+63
      s4_div   <= {s3_root, 4'b0000};
      s4_plain <= s3_plain;
    end
  end

  // stage 5: quotient bits 3 and 2
  logic [12:0] rem5_a, rem5_b, t5_3, t5_2;
  logic [1:0]  q5_c;
  logic s5_sat, s5_small;
  logic [pcg_pkg::KEY_W-1:0] s5_key;
  logic [pcg_pkg::ROOT_W-1:0] s5_root;
  logic [pcg_pkg::NUM_W-1:0] s5_rem;
  logic [pcg_pkg::DIV_W-1:0] s5_div;
  logic [1:0] s5_q;
  logic [7:0] s5_plain;

  always_comb begin
    t5_3   = 13'(s4_div) << 3;
    t5_2   = 13'(s4_div) << 2;
    rem5_a = 13'(s4_num);
    q5_c[1] = rem5_a >= t5_3;
    if (q5_c[1]) begin
      rem5_a = rem5_a - t5_3;
    end
    rem5_b = rem5_a;
    q5_c[0] = rem5_b >= t5_2;
    if (q5_c[0]) begin
      rem5_b = rem5_b - t5_2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sat   <= s4_sat;
      s5_small <= s4_small;
      s5_key   <= s4_key;
      s5_root  <= s4_root;
      s5_rem   <= rem5_b[pcg_pkg::NUM_W-1:0];
      s5_div   <= s4_div;
      s5_q     <= q5_c;
      s5_plain <= s4_plain;
    end
  end

  // stage 6: quotient bits 1 and 0
  logic [12:0] rem6_a, rem6_b, t6_1, t6_0;
  logic [1:0]  q6_c;
  logic s6_sat, s6_small;
  logic [pcg_pkg::KEY_W-1:0] s6_key;
  logic [pcg_pkg::ROOT_W-1:0] s6_root;
  logic [pcg_pkg::NUM_W-1:0] s6_rem;
  logic [pcg_pkg::DIV_W-1:0] s6_div;
  logic [pcg_pkg::QUO_W-1:0] s6_q;
  logic [7:0] s6_plain;

  always_comb begin
    t6_1   = 13'(s5_div) << 1;
    t6_0   = 13'(s5_div);
    rem6_a = 13'(s5_rem);
    q6_c[1] = rem6_a >= t6_1;
    if (q6_c[1]) begin
      rem6_a = rem6_a - t6_1;
    end
    rem6_b = rem6_a;
    q6_c[0] = rem6_b >= t6_0;
    if (q6_c[0]) begin
      rem6_b = rem6_b - t6_0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_sat   <= s5_sat;
      s6_small <= s5_small;
      s6_key   <= s5_key;
      s6_root  <= s5_root;
      s6_rem   <= rem6_b[pcg_pkg::NUM_W-1:0];
      s6_div   <= s5_div;
      s6_q     <= {s5_q, q6_c};
      s6_plain <= s5_plain;
    end
  end

  // stage 7: refined root, step down when its square overshoots, mode select and invert
  logic [8:0]  root_ref;
  logic [17:0] root_sq;
  logic [8:0]  root_fix;
  logic [7:0]  root_out;
  logic [7:0]  dist_val;
  logic [7:0]  val_sel;
  logic [7:0]  chan_value_next;

  always_comb begin
    root_ref = {1'b0, s6_root, 3'b000} + 9'(s6_q);
    root_sq  = 18'(root_ref) * 18'(root_ref);
    root_fix = root_ref - 9'(root_sq > 18'(s6_key));
    if (s6_sat) begin
      root_out = pcg_pkg::CHAN_MAX;
    end else if (s6_small) begin
      root_out = 8'(s6_root);
    end else begin
      root_out = root_fix[7:0];
    end
    dist_val = ~root_out;
    val_sel  = (fill_mode == pcg_pkg::MODE_DIST) ? dist_val : s6_plain;
    chan_value_next = invert_output ? ~val_sel : val_sel;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chan_value <= chan_value_next;
    end
  end

  // refinement checks on the distance path
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (v6 && !s6_sat && !s6_small) |-> (13'(s6_rem) < 13'(s6_div)))
    else $error("refinement remainder not below divisor");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (v6 && !s6_sat && !s6_small) |-> (s6_q <= 4'd8))
    else $error("refinement quotient above eight");

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    (v6 && !s6_sat && !s6_small) |-> (root_fix <= 9'd255))
    else $error("corrected root exceeds a byte");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v6))
    else $error("output word without a stage six word");

endmodule

// ===== tb/pixel_channel_generator_core_tb.sv =====
// testbench of the pixel channel generator core: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module pixel_channel_generator_core_tb;

  // fill modes with no meaning, and register indexes past the last one
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [2:0] CFG_SPARE_A  = 3'd6;
  localparam logic [2:0] CFG_SPARE_B  = 3'd7;

  localparam logic [31:0] SCALE_AT_RESET = 32'd4261478400;   // 65025.0 in q16.16
  localparam logic [63:0] SAT_PRODUCT    = 64'd65025 << 16;
  localparam int          LONG_HOLD      = 400;              // cycles of output back-pressure

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_word_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] data;
  } cfg_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pix_red = '0;
  logic [7:0]  pix_green = '0;
  logic [7:0]  pix_blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  chan_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pixel_channel_generator_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pix_red    (pix_red),
    .pix_green  (pix_green),
    .pix_blue   (pix_blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .chan_value (chan_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // pending stimulus and the channel bytes still owed by the block
  pixel_word_t pixel_q[$];
  cfg_word_t   cfg_q[$];
  logic [7:0]  chan_expect_q[$];
  int          pix_pending = 0;
  int          cfg_pending = 0;
  int          fail_cnt = 0;

  // shadow copy of the configuration, updated when a register write is accepted
  logic [2:0]  mode_sh;
  logic        invert_sh;
  logic [7:0]  ref_r_sh;
  logic [7:0]  ref_g_sh;
  logic [7:0]  ref_b_sh;
  logic [31:0] scale_sh;

  // idling controls, set per phase
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;

  int          in_gap = 0;
  int          ready_hold = 0;
  int          ready_stall;
  pixel_word_t pix_w;
  cfg_word_t   cfg_w;
  logic [7:0]  chan_want;

  initial begin
    forever #5 clk = ~clk;
  end

  // generous wall clock limit, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [17:0] byte_diff_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return 18'(d) * 18'(d);
  endfunction

  // plain floor square root, capped at 31 like the seed root
  function automatic logic [31:0] floor_root(input logic [31:0] k);
    logic [31:0] r;
    r = '0;
    for (int i = 1; i < 32; i++) begin
      if (32'(i * i) <= k) r = 32'(i);
    end
    return r;
  endfunction

  // inverted root of the scaled squared distance to colour a
  function automatic logic [7:0] distance_chan(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    logic [17:0] dist_sq;
    logic [63:0] prod;
    logic [31:0] key;
    logic [31:0] root;
    logic [31:0] resid;
    dist_sq = byte_diff_sq(r, ref_r_sh) + byte_diff_sq(g, ref_g_sh)
            + byte_diff_sq(b, ref_b_sh);
    prod = 64'(scale_sh) * 64'(dist_sq);
    if (prod >= SAT_PRODUCT) begin
      root = 32'd255;
    end else begin
      key = prod[47:16];
      if (key < 32'd1024) begin
        root = floor_root(key);
      end else begin
        // seed from the top bits, one newton step, then pull down if it overshot
        root = floor_root((key >> 6) & 32'd1023) << 3;
        root = root + (key - root * root) / (root + root);
        resid = key - root * root;
        root = root - {31'b0, resid[17]};
      end
    end
    return root[7:0] ^ 8'hFF;
  endfunction

  function automatic logic [7:0] predict_chan(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    logic [7:0] v;
    case (mode_sh)
      pcg_pkg::MODE_SET:   v = 8'hFF;
      pcg_pkg::MODE_DIST:  v = distance_chan(r, g, b);
      pcg_pkg::MODE_RED:   v = r;
      pcg_pkg::MODE_GREEN: v = g;
      pcg_pkg::MODE_BLUE:  v = b;
      default:             v = 8'h00;   // clear and the two spare modes
    endcase
    if (invert_sh) v = v ^ 8'hFF;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: one word per handshake, random gap drawn per word
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        chan_expect_q.push_back(predict_chan(pix_red, pix_green, pix_blue));
        pix_pending--;
      end
      // the slot is free when nothing is offered or the offer just went through
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pix_w     = pixel_q.pop_front();
          in_valid  <= 1'b1;
          pix_red   <= pix_w.red;
          pix_green <= pix_w.green;
          pix_blue  <= pix_w.blue;
          in_gap    <= in_idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register writer, keeps the shadow configuration in step with the block
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      mode_sh   <= pcg_pkg::MODE_CLEAR;
      invert_sh <= 1'b0;
      ref_r_sh  <= '0;
      ref_g_sh  <= '0;
      ref_b_sh  <= '0;
      scale_sh  <= SCALE_AT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pcg_pkg::REG_FILL_MODE:     mode_sh   <= cfg_data[2:0];
          pcg_pkg::REG_INVERT_OUTPUT: invert_sh <= cfg_data[0];
          pcg_pkg::REG_REF_RED:       ref_r_sh  <= cfg_data[7:0];
          pcg_pkg::REG_REF_GREEN:     ref_g_sh  <= cfg_data[7:0];
          pcg_pkg::REG_REF_BLUE:      ref_b_sh  <= cfg_data[7:0];
          pcg_pkg::REG_RADIUS_SCALE:  scale_sh  <= cfg_data;
          default: ;         // spare indexes are dropped
        endcase
        cfg_pending--;
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() != 0) begin
          cfg_w     = cfg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= cfg_w.idx;
          cfg_data  <= cfg_w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor and ready generator
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (chan_expect_q.size() == 0) begin
          $error("chan_value: expected none, actual %0d", chan_value);
          fail_cnt++;
        end else begin
          chan_want = chan_expect_q.pop_front();
          if (chan_value !== chan_want) begin
            $error("chan_value: expected %0d, actual %0d", chan_want, chan_value);
            fail_cnt++;
          end
        end
      end
      // one long back-pressure stretch so the pipe fills and stalls its input
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        ready_hold     <= LONG_HOLD;
        out_ready      <= 1'b0;
      end else if (ready_hold != 0) begin
        ready_hold <= ready_hold - 1;
        out_ready  <= (ready_hold == 1);
      end else if (out_valid && out_ready && out_idle_on) begin
        ready_stall = $urandom_range(0, 15);
        ready_hold  <= ready_stall;
        out_ready   <= (ready_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // wait until no write and no pixel is in flight
  task automatic settle();
    while (cfg_pending != 0 || pix_pending != 0 || chan_expect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_q.push_back('{idx: idx, data: data});
    cfg_pending++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    settle();
    queue_reg(idx, data);
    settle();
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_q.push_back('{red: r, green: g, blue: b});
    pix_pending++;
  endtask

  function automatic logic [7:0] biased_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // a component within a few steps of the given one
  function automatic logic [7:0] near_byte(input logic [7:0] a);
    int v;
    v = int'(a) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // one phase: fresh configuration, then a burst of pixels
  task automatic random_phase(input int count, input bit squeeze);
    logic [7:0]  ar, ag, ab;
    logic [7:0]  br, bg, bb;
    logic [17:0] dab;
    logic [31:0] scale;
    logic [2:0]  mode;
    ar = biased_byte();
    ag = biased_byte();
    ab = biased_byte();
    br = biased_byte();
    bg = biased_byte();
    bb = biased_byte();
    mode = ($urandom_range(0, 1) == 1) ? 3'(pcg_pkg::MODE_DIST) : 3'($urandom_range(0, 7));
    // scale as software would set it from colour b, with some odd values mixed in
    dab = byte_diff_sq(ar, br) + byte_diff_sq(ag, bg) + byte_diff_sq(ab, bb);
    case ($urandom_range(0, 9))
      0:       scale = 32'h0000_0000;
      1:       scale = 32'hFFFF_FFFF;
      2:       scale = $urandom;
      default: scale = (dab == 0) ? SCALE_AT_RESET : 32'(SAT_PRODUCT / 64'(dab));
    endcase
    settle();
    // upper data bits are junk on purpose, only the low bits of the narrow registers count
    queue_reg(pcg_pkg::REG_FILL_MODE, {29'($urandom), mode});
    queue_reg(pcg_pkg::REG_INVERT_OUTPUT, {31'($urandom), 1'($urandom)});
    queue_reg(pcg_pkg::REG_REF_RED, {24'($urandom), ar});
    queue_reg(pcg_pkg::REG_REF_GREEN, {24'($urandom), ag});
    queue_reg(pcg_pkg::REG_REF_BLUE, {24'($urandom), ab});
    queue_reg(pcg_pkg::REG_RADIUS_SCALE, scale);
    if ($urandom_range(0, 3) == 0)
      queue_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
    settle();
    in_idle_on  = squeeze ? 1'b0 : 1'($urandom_range(0, 1));
    out_idle_on = squeeze ? 1'b0 : 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        1:       queue_pixel(near_byte(ar), near_byte(ag), near_byte(ab));
        2:       queue_pixel(near_byte(br), near_byte(bg), near_byte(bb));
        default: queue_pixel(biased_byte(), biased_byte(), biased_byte());
      endcase
    end
    if (squeeze) long_hold_req = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // register reset values: clear mode gives zero everywhere
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);

    // constant and copy modes
    write_reg(pcg_pkg::REG_FILL_MODE, 32'(pcg_pkg::MODE_SET));
    queue_pixel(8'd12, 8'd34, 8'd56);
    write_reg(pcg_pkg::REG_FILL_MODE, 32'(pcg_pkg::MODE_RED));
    queue_pixel(8'hA5, 8'h5A, 8'hFF);
    write_reg(pcg_pkg::REG_FILL_MODE, 32'(pcg_pkg::MODE_GREEN));
    queue_pixel(8'hA5, 8'h5A, 8'hFF);
    write_reg(pcg_pkg::REG_FILL_MODE, 32'(pcg_pkg::MODE_BLUE));
    queue_pixel(8'hA5, 8'h5A, 8'hFF);

    // invert with junk upper bits
    write_reg(pcg_pkg::REG_INVERT_OUTPUT, 32'hFFFF_FFFF);
    queue_pixel(8'h3C, 8'hC3, 8'h00);

    // spare modes behave as clear, still inverted
    write_reg(pcg_pkg::REG_FILL_MODE, {29'h1FFF_FFFF, MODE_SPARE_A});
    queue_pixel(8'h77, 8'h88, 8'h99);
    write_reg(pcg_pkg::REG_FILL_MODE, 32'(MODE_SPARE_B));
    queue_pixel(8'h77, 8'h88, 8'h99);

    // distance at reset scale: exact match, then saturation at distance one
    write_reg(pcg_pkg::REG_INVERT_OUTPUT, 32'hFFFF_FFFE);
    write_reg(pcg_pkg::REG_FILL_MODE, 32'(pcg_pkg::MODE_DIST));
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd1, 8'd0, 8'd0);

    // unit scale: small root path, first refined key, last key, saturation
    write_reg(pcg_pkg::REG_RADIUS_SCALE, 32'h0001_0000);
    queue_pixel(8'd30, 8'd10, 8'd0);
    queue_pixel(8'd32, 8'd0, 8'd0);
    queue_pixel(8'd240, 8'd80, 8'd32);
    queue_pixel(8'd255, 8'd0, 8'd0);

    // white reference, zero scale against the farthest pixel
    write_reg(pcg_pkg::REG_REF_RED, 32'hFFFF_FFFF);
    write_reg(pcg_pkg::REG_REF_GREEN, 32'hFFFF_FFFF);
    write_reg(pcg_pkg::REG_REF_BLUE, 32'hFFFF_FFFF);
    write_reg(pcg_pkg::REG_RADIUS_SCALE, 32'h0000_0000);
    queue_pixel(8'd0, 8'd0, 8'd0);

    // largest scale
    write_reg(pcg_pkg::REG_RADIUS_SCALE, 32'hFFFF_FFFF);
    queue_pixel(8'd255, 8'd255, 8'd254);
    queue_pixel(8'd255, 8'd255, 8'd255);

    // writes past the last register leave everything alone
    write_reg(CFG_SPARE_A, 32'h0000_0000);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    queue_pixel(8'd255, 8'd255, 8'd255);

    // random phases, one of them with the long output stall
    for (int ph = 0; ph < 12; ph++)
      random_phase(150, ph == 3);

    settle();
    repeat (12) @(posedge clk);
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pcg_pkg.sv
rtl/core/pixel_channel_generator_core.sv
tb/pixel_channel_generator_core_tb.sv
